### rtl/core/ecc3_pkg.sv
// Shared types, constants and trit helpers for the GF(3^m) point arithmetic core.
// Used by ecc3_ctrl, ecc3_dp, ecc3_inv and the top level; depends on nothing.
package ecc3_pkg;

  localparam int IN_TRITS = 31;
  localparam int FIELD_W  = 62;
  localparam int DEG_W    = 5;
  localparam int CNT_W    = 5;

  // configuration register indexes
  localparam logic [1:0] REG_DEGREE  = 2'd0;
  localparam logic [1:0] REG_MODULUS = 2'd1;
  localparam logic [1:0] REG_A2      = 2'd2;
  localparam logic [1:0] REG_A4      = 2'd3;

  typedef enum logic [2:0] {
    OP_SUB,
    OP_MUL,
    OP_INV,
    OP_LOAD,
    OP_OUT
  } op_t;

  typedef enum logic [3:0] {
    R_A2,
    R_A4,
    R_AX,
    R_AY,
    R_BX,
    R_BY,
    R_LAM,
    R_T,
    R_U,
    R_ZERO
  } reg_t;

  typedef enum logic [2:0] {
    RAW_A2,
    RAW_A4,
    RAW_FX,
    RAW_FY,
    RAW_SX,
    RAW_SY
  } raw_t;

  typedef struct packed {
    logic valid;
    op_t  op;
    reg_t dst;
    reg_t src1;
    reg_t src2;
    raw_t raw;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic zero;
  } stat_t;

  typedef enum logic [5:0] {
    ST_IDLE,
    ST_LD_A2,
    ST_LD_A4,
    ST_LD_FX,
    ST_LD_FY,
    ST_LD_SX,
    ST_LD_SY,
    ST_ADD_CHK,
    ST_CP_X,
    ST_CP_Y,
    ST_NEG,
    ST_CMP_X,
    ST_CMP_NY,
    ST_CMP_Y,
    ST_DY,
    ST_DX,
    ST_INV_D,
    ST_LAM_C,
    ST_DBL_CHK,
    ST_DBL_M,
    ST_DBL_S,
    ST_DBL_I,
    ST_DBL_L,
    ST_F_SQ,
    ST_F_A2,
    ST_F_X1,
    ST_F_X2,
    ST_F_D,
    ST_F_M,
    ST_F_Y,
    ST_F_CX,
    ST_F_CY,
    ST_NEXT,
    ST_BIT,
    ST_DBL_B,
    ST_OUT,
    ST_DONE
  } state_t;

  // map the unused code to zero
  function automatic logic [1:0] tclean(input logic [1:0] t);
    return (t == 2'd3) ? 2'd0 : t;
  endfunction

  function automatic logic [1:0] tadd(input logic [1:0] a, input logic [1:0] b);
    logic [2:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= 3'd3) ? 2'(s - 3'd3) : s[1:0];
  endfunction

  function automatic logic [1:0] tneg(input logic [1:0] b);
    logic [1:0] r;
    case (b)
      2'd1:    r = 2'd2;
      2'd2:    r = 2'd1;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] tsub(input logic [1:0] a, input logic [1:0] b);
    return tadd(a, tneg(b));
  endfunction

  function automatic logic [1:0] tmul(input logic [1:0] a, input logic [1:0] b);
    logic [1:0] r;
    if (a == 2'd0 || b == 2'd0) r = 2'd0;
    else if (a == b) r = 2'd1;
    else r = 2'd2;
    return r;
  endfunction

endpackage

### rtl/core/ecc3_inv.sv
// Field inverse by extended Euclid, one subtract-or-swap step per cycle.
// Depends on ecc3_pkg for the trit helpers.
module ecc3_inv import ecc3_pkg::*; #(
  parameter int MAXD = 31
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [2*MAXD-1:0] a,
  input  logic [2*MAXD+1:0] modp,
  output logic              done,
  output logic [2*MAXD-1:0] inv
);

  localparam int NT = MAXD + 1;
  localparam int VW = 2 * NT;
  localparam int EW = 2 * MAXD;
  localparam int DW = $clog2(NT);

  logic          busy;
  logic [VW-1:0] r0, r1, s0, s1;
  logic [VW-1:0] r1s, s1s, r0_sub, s0_sub;
  logic [EW-1:0] scaled;
  logic [DW-1:0] d0, d1, sh;
  logic          z0, z1;
  logic [1:0]    c;

  function automatic logic [DW-1:0] pdeg(input logic [VW-1:0] v);
    logic [DW-1:0] d;
    d = '0;
    for (int j = 0; j < NT; j++) begin
      if (v[2*j +: 2] != 2'd0) d = DW'(j);
    end
    return d;
  endfunction

  // leading terms and aligned divisor
  always_comb begin
    d0  = pdeg(r0);
    d1  = pdeg(r1);
    z0  = ~|r0;
    z1  = ~|r1;
    sh  = d0 - d1;
    c   = tmul(r0[2*d0 +: 2], r1[2*d1 +: 2]);
    r1s = r1 << {sh, 1'b0};
    s1s = s1 << {sh, 1'b0};
  end

  for (genvar j = 0; j < NT; j++) begin : g_sub
    assign r0_sub[2*j +: 2] = tsub(r0[2*j +: 2], tmul(c, r1s[2*j +: 2]));
    assign s0_sub[2*j +: 2] = tsub(s0[2*j +: 2], tmul(c, s1s[2*j +: 2]));
  end

  // normalize by the constant gcd
  for (genvar j = 0; j < MAXD; j++) begin : g_scale
    assign scaled[2*j +: 2] = tmul(s0[2*j +: 2], r0[1:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (start) begin
        busy <= 1'b1;
      end else if (busy && z1) begin
        busy <= 1'b0;
      end
      done <= !start && busy && z1;
    end
  end

  // remainder sequence
  always_ff @(posedge clk) begin
    if (start) begin
      r0 <= modp;
      r1 <= VW'(a);
      s0 <= '0;
      s1 <= VW'(1);
    end else if (busy && !z1) begin
      if (z0 || d0 < d1) begin
        r0 <= r1;
        r1 <= r0;
        s0 <= s1;
        s1 <= s0;
      end else begin
        r0 <= r0_sub;
        s0 <= s0_sub;
      end
    end
    if (busy && z1) inv <= (!z0 && d0 == '0) ? scaled : '0;
  end

endmodule

### rtl/core/ecc3_dp.sv
// Datapath: element register file, trit subtract, serial multiply/reduce, inverse.
// Depends on ecc3_pkg and ecc3_inv.
module ecc3_dp import ecc3_pkg::*; #(
  parameter int MAXD = 31
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               capture,
  input  logic [FIELD_W-1:0] first_x,
  input  logic [FIELD_W-1:0] first_y,
  input  logic [FIELD_W-1:0] second_x,
  input  logic [FIELD_W-1:0] second_y,
  input  logic [DEG_W-1:0]   field_degree,
  input  logic [FIELD_W-1:0] modulus_low,
  input  logic [FIELD_W-1:0] coeff_a2,
  input  logic [FIELD_W-1:0] coeff_a4,
  input  cmd_t               cmd,
  output stat_t              stat,
  output logic [FIELD_W-1:0] result_x,
  output logic [FIELD_W-1:0] result_y
);

  localparam int EW = 2 * MAXD;
  localparam int NT = MAXD + 1;
  localparam int VW = 2 * NT;

  logic [EW-1:0]      rf [16];
  logic [FIELD_W-1:0] cap_fx, cap_fy, cap_sx, cap_sy;
  logic [FIELD_W-1:0] raw_sel, raw_clean, sa;
  logic [EW-1:0]      opa, opb, sb, acc, acc_next, diff, wr_data, inv_out;
  logic [VW-1:0]      modp;
  logic [DEG_W-1:0]   m_eff, mtop;
  logic [CNT_W-1:0]   ser_cnt;
  logic [1:0]         c_top, a_top;
  cmd_t               cmd_q;
  logic               exec_go, ser_act, ser_last, wr_en, out_go, inv_start, inv_done;

  // clamp the degree
  always_comb begin
    if (field_degree == '0) m_eff = DEG_W'(1);
    else if (field_degree > DEG_W'(MAXD)) m_eff = DEG_W'(MAXD);
    else m_eff = field_degree;
    mtop = m_eff - 1'b1;
  end

  // full modulus with its leading one
  for (genvar j = 0; j < NT; j++) begin : g_mod
    if (j < IN_TRITS) begin : g_low
      assign modp[2*j +: 2] = (DEG_W'(j) < m_eff) ? tclean(modulus_low[2*j +: 2]) :
                              ((DEG_W'(j) == m_eff) ? 2'd1 : 2'd0);
    end else begin : g_top
      assign modp[2*j +: 2] = (DEG_W'(j) == m_eff) ? 2'd1 : 2'd0;
    end
  end

  always_comb begin
    case (cmd_q.raw)
      RAW_A2:  raw_sel = coeff_a2;
      RAW_A4:  raw_sel = coeff_a4;
      RAW_FX:  raw_sel = cap_fx;
      RAW_FY:  raw_sel = cap_fy;
      RAW_SX:  raw_sel = cap_sx;
      RAW_SY:  raw_sel = cap_sy;
      default: raw_sel = '0;
    endcase
  end

  for (genvar j = 0; j < IN_TRITS; j++) begin : g_clean
    assign raw_clean[2*j +: 2] = tclean(raw_sel[2*j +: 2]);
  end

  assign c_top = acc[2*mtop +: 2];
  assign a_top = sa[FIELD_W-1 -: 2];

  // one Horner step: acc*x mod p plus a_i*b; also the trit difference
  for (genvar j = 0; j < MAXD; j++) begin : g_mul
    logic [1:0] prev, red;
    if (j == 0) begin : g_lo
      assign prev = 2'd0;
    end else begin : g_hi
      assign prev = acc[2*j-1 -: 2];
    end
    assign red = tsub(prev, tmul(c_top, modp[2*j +: 2]));
    assign acc_next[2*j +: 2] = (DEG_W'(j) < m_eff) ?
                                tadd(red, tmul(a_top, sb[2*j +: 2])) : 2'd0;
    assign diff[2*j +: 2] = tsub(opa[2*j +: 2], opb[2*j +: 2]);
  end

  assign ser_last  = (ser_cnt == CNT_W'(IN_TRITS - 1));
  assign out_go    = exec_go && cmd_q.op == OP_OUT;
  assign inv_start = exec_go && cmd_q.op == OP_INV;

  ecc3_inv #(.MAXD(MAXD)) u_inv (
    .clk   (clk),
    .rst   (rst),
    .start (inv_start),
    .a     (opa),
    .modp  (modp),
    .done  (inv_done),
    .inv   (inv_out)
  );

  // pick the write-back source
  always_comb begin
    wr_en   = 1'b0;
    wr_data = diff;
    if (exec_go && cmd_q.op == OP_SUB) begin
      wr_en = 1'b1;
    end else if (ser_act && ser_last) begin
      wr_en   = 1'b1;
      wr_data = acc_next;
    end else if (inv_done) begin
      wr_en   = 1'b1;
      wr_data = inv_out;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) rf[cmd_q.dst] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      exec_go <= 1'b0;
      ser_act <= 1'b0;
      stat    <= '0;
    end else begin
      exec_go   <= cmd.valid;
      stat.done <= wr_en || out_go;
      stat.zero <= ~|wr_data;
      if (exec_go && (cmd_q.op == OP_LOAD || cmd_q.op == OP_MUL)) ser_act <= 1'b1;
      else if (ser_act && ser_last) ser_act <= 1'b0;
    end
  end

  // operand read, serial unit, result word
  always_ff @(posedge clk) begin
    if (capture) begin
      cap_fx <= first_x;
      cap_fy <= first_y;
      cap_sx <= second_x;
      cap_sy <= second_y;
    end
    if (cmd.valid) begin
      cmd_q <= cmd;
      opa   <= (cmd.src1 == R_ZERO) ? '0 : rf[cmd.src1];
      opb   <= (cmd.src2 == R_ZERO) ? '0 : rf[cmd.src2];
    end
    if (exec_go) begin
      ser_cnt <= '0;
      acc     <= '0;
      if (cmd_q.op == OP_LOAD) begin
        sa <= raw_clean;
        sb <= EW'(1);
      end else begin
        sa <= FIELD_W'(opa);
        sb <= opb;
      end
    end else if (ser_act) begin
      acc     <= acc_next;
      sa      <= sa << 2;
      ser_cnt <= ser_cnt + 1'b1;
    end
    if (out_go) begin
      result_x <= FIELD_W'(opa);
      result_y <= FIELD_W'(opb);
    end
  end

endmodule

### rtl/core/ecc3_ctrl.sv
// Controller: sequences point addition, doubling and the double-and-add loop
// as field commands to the datapath. Depends on ecc3_pkg.
module ecc3_ctrl import ecc3_pkg::*; #(
  parameter int SCALAR_BITS = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic                   kind,
  input  logic                   first_inf,
  input  logic                   second_inf,
  input  logic [SCALAR_BITS-1:0] scalar,
  input  stat_t                  stat,
  output cmd_t                   cmd,
  output logic                   busy,
  output logic                   done,
  output logic                   result_inf
);

  state_t                 state, state_next;
  logic                   issued, issued_next;
  logic                   kind_q, kind_next;
  logic                   ainf, ainf_next, binf, binf_next;
  logic                   tgt_b, tgt_b_next, chord, chord_next;
  logic                   zx, zx_next, zn, zn_next;
  logic                   res_inf_next;
  logic [SCALAR_BITS-1:0] k, k_next;
  reg_t                   px, py, qx;

  function automatic cmd_t mk(input op_t op, input reg_t d, input reg_t s1, input reg_t s2);
    cmd_t c;
    c.valid = 1'b0;
    c.op    = op;
    c.dst   = d;
    c.src1  = s1;
    c.src2  = s2;
    c.raw   = RAW_A2;
    return c;
  endfunction

  // point being worked on and the second x of the finish step
  assign px = tgt_b ? R_BX : R_AX;
  assign py = tgt_b ? R_BY : R_AY;
  assign qx = chord ? R_BX : px;

  assign busy = (state != ST_IDLE);
  assign done = (state == ST_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      issued <= 1'b0;
    end else begin
      state  <= state_next;
      issued <= issued_next;
    end
  end

  always_ff @(posedge clk) begin
    kind_q     <= kind_next;
    ainf       <= ainf_next;
    binf       <= binf_next;
    tgt_b      <= tgt_b_next;
    chord      <= chord_next;
    zx         <= zx_next;
    zn         <= zn_next;
    k          <= k_next;
    result_inf <= res_inf_next;
  end

  always_comb begin
    state_next   = state;
    kind_next    = kind_q;
    ainf_next    = ainf;
    binf_next    = binf;
    tgt_b_next   = tgt_b;
    chord_next   = chord;
    zx_next      = zx;
    zn_next      = zn;
    k_next       = k;
    res_inf_next = result_inf;
    cmd          = mk(OP_SUB, R_T, R_ZERO, R_ZERO);
    case (state)
      ST_IDLE: begin
        if (start) begin
          kind_next  = kind;
          ainf_next  = kind ? 1'b1 : first_inf;
          binf_next  = kind ? first_inf : second_inf;
          k_next     = scalar;
          tgt_b_next = 1'b0;
          state_next = ST_LD_A2;
        end
      end
      // load and reduce curve and point values
      ST_LD_A2: begin
        cmd = mk(OP_LOAD, R_A2, R_ZERO, R_ZERO);
        if (stat.done) state_next = ST_LD_A4;
      end
      ST_LD_A4: begin
        cmd     = mk(OP_LOAD, R_A4, R_ZERO, R_ZERO);
        cmd.raw = RAW_A4;
        if (stat.done) state_next = ST_LD_FX;
      end
      ST_LD_FX: begin
        cmd     = mk(OP_LOAD, kind_q ? R_BX : R_AX, R_ZERO, R_ZERO);
        cmd.raw = RAW_FX;
        if (stat.done) state_next = ST_LD_FY;
      end
      ST_LD_FY: begin
        cmd     = mk(OP_LOAD, kind_q ? R_BY : R_AY, R_ZERO, R_ZERO);
        cmd.raw = RAW_FY;
        if (stat.done) state_next = kind_q ? ST_BIT : ST_LD_SX;
      end
      ST_LD_SX: begin
        cmd     = mk(OP_LOAD, R_BX, R_ZERO, R_ZERO);
        cmd.raw = RAW_SX;
        if (stat.done) state_next = ST_LD_SY;
      end
      ST_LD_SY: begin
        cmd     = mk(OP_LOAD, R_BY, R_ZERO, R_ZERO);
        cmd.raw = RAW_SY;
        if (stat.done) state_next = ST_ADD_CHK;
      end
      // A = A + B
      ST_ADD_CHK: begin
        tgt_b_next = 1'b0;
        if (ainf && binf) state_next = ST_NEXT;
        else if (ainf) state_next = ST_CP_X;
        else if (binf) state_next = ST_NEXT;
        else state_next = ST_NEG;
      end
      ST_CP_X: begin
        cmd = mk(OP_SUB, R_AX, R_BX, R_ZERO);
        if (stat.done) state_next = ST_CP_Y;
      end
      ST_CP_Y: begin
        cmd = mk(OP_SUB, R_AY, R_BY, R_ZERO);
        if (stat.done) begin
          ainf_next  = 1'b0;
          state_next = ST_NEXT;
        end
      end
      ST_NEG: begin
        cmd = mk(OP_SUB, R_U, R_ZERO, R_AY);
        if (stat.done) state_next = ST_CMP_X;
      end
      ST_CMP_X: begin
        cmd = mk(OP_SUB, R_T, R_AX, R_BX);
        if (stat.done) begin
          zx_next    = stat.zero;
          state_next = ST_CMP_NY;
        end
      end
      ST_CMP_NY: begin
        cmd = mk(OP_SUB, R_T, R_U, R_BY);
        if (stat.done) begin
          zn_next    = stat.zero;
          state_next = ST_CMP_Y;
        end
      end
      ST_CMP_Y: begin
        cmd = mk(OP_SUB, R_T, R_AY, R_BY);
        if (stat.done) begin
          if (zx && zn) begin
            ainf_next  = 1'b1;
            state_next = ST_NEXT;
          end else if (zx && stat.zero) begin
            chord_next = 1'b0;
            state_next = ST_DBL_CHK;
          end else begin
            chord_next = 1'b1;
            state_next = ST_DY;
          end
        end
      end
      // chord slope
      ST_DY: begin
        cmd = mk(OP_SUB, R_LAM, R_BY, R_AY);
        if (stat.done) state_next = ST_DX;
      end
      ST_DX: begin
        cmd = mk(OP_SUB, R_T, R_BX, R_AX);
        if (stat.done) state_next = ST_INV_D;
      end
      ST_INV_D: begin
        cmd = mk(OP_INV, R_T, R_T, R_ZERO);
        if (stat.done) state_next = ST_LAM_C;
      end
      ST_LAM_C: begin
        cmd = mk(OP_MUL, R_LAM, R_LAM, R_T);
        if (stat.done) state_next = ST_F_SQ;
      end
      // tangent slope, or infinity for y = 0
      ST_DBL_CHK: begin
        cmd = mk(OP_SUB, R_T, py, R_ZERO);
        if (stat.done) begin
          if (stat.zero) begin
            if (tgt_b) binf_next = 1'b1;
            else ainf_next = 1'b1;
            state_next = ST_NEXT;
          end else begin
            state_next = ST_DBL_M;
          end
        end
      end
      ST_DBL_M: begin
        cmd = mk(OP_MUL, R_LAM, R_A2, px);
        if (stat.done) state_next = ST_DBL_S;
      end
      ST_DBL_S: begin
        cmd = mk(OP_SUB, R_LAM, R_LAM, R_A4);
        if (stat.done) state_next = ST_DBL_I;
      end
      ST_DBL_I: begin
        cmd = mk(OP_INV, R_T, py, R_ZERO);
        if (stat.done) state_next = ST_DBL_L;
      end
      ST_DBL_L: begin
        cmd = mk(OP_MUL, R_LAM, R_LAM, R_T);
        if (stat.done) state_next = ST_F_SQ;
      end
      // x3 = lam^2 - a2 - x1 - x2, y3 = lam*(x1 - x3) - y1
      ST_F_SQ: begin
        cmd = mk(OP_MUL, R_T, R_LAM, R_LAM);
        if (stat.done) state_next = ST_F_A2;
      end
      ST_F_A2: begin
        cmd = mk(OP_SUB, R_T, R_T, R_A2);
        if (stat.done) state_next = ST_F_X1;
      end
      ST_F_X1: begin
        cmd = mk(OP_SUB, R_T, R_T, px);
        if (stat.done) state_next = ST_F_X2;
      end
      ST_F_X2: begin
        cmd = mk(OP_SUB, R_T, R_T, qx);
        if (stat.done) state_next = ST_F_D;
      end
      ST_F_D: begin
        cmd = mk(OP_SUB, R_U, px, R_T);
        if (stat.done) state_next = ST_F_M;
      end
      ST_F_M: begin
        cmd = mk(OP_MUL, R_U, R_U, R_LAM);
        if (stat.done) state_next = ST_F_Y;
      end
      ST_F_Y: begin
        cmd = mk(OP_SUB, R_U, R_U, py);
        if (stat.done) state_next = ST_F_CX;
      end
      ST_F_CX: begin
        cmd = mk(OP_SUB, px, R_T, R_ZERO);
        if (stat.done) state_next = ST_F_CY;
      end
      ST_F_CY: begin
        cmd = mk(OP_SUB, py, R_U, R_ZERO);
        if (stat.done) begin
          if (tgt_b) binf_next = 1'b0;
          else ainf_next = 1'b0;
          state_next = ST_NEXT;
        end
      end
      // advance the double-and-add loop
      ST_NEXT: begin
        if (!kind_q) begin
          state_next = ST_OUT;
        end else if (!tgt_b) begin
          state_next = ST_DBL_B;
        end else begin
          k_next     = k >> 1;
          state_next = ST_BIT;
        end
      end
      ST_BIT: begin
        if (binf || k == '0) state_next = ST_OUT;
        else if (k[0]) state_next = ST_ADD_CHK;
        else state_next = ST_DBL_B;
      end
      ST_DBL_B: begin
        tgt_b_next = 1'b1;
        chord_next = 1'b0;
        state_next = ST_DBL_CHK;
      end
      ST_OUT: begin
        cmd = mk(OP_OUT, R_T, ainf ? R_ZERO : R_AX, ainf ? R_ZERO : R_AY);
        if (stat.done) begin
          res_inf_next = ainf;
          state_next   = ST_DONE;
        end
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    cmd.valid = 1'b0;
    if (state != ST_IDLE && state != ST_ADD_CHK && state != ST_NEXT && state != ST_BIT &&
        state != ST_DBL_B && state != ST_DONE) begin
      cmd.valid = !issued;
    end
    if (cmd.valid) issued_next = 1'b1;
    else if (stat.done) issued_next = 1'b0;
    else issued_next = issued;
  end

endmodule

### rtl/core/ecc_point_add_scalar_mul_gf3.sv
// Top level: configuration registers, controller and datapath of the
// GF(3^m) affine point adder / scalar multiplier. Depends on ecc3_pkg,
// ecc3_ctrl and ecc3_dp.
//
// One word is taken when start is high and busy is low; busy stays high until
// the result word is shown on result_x, result_y and result_inf for exactly one
// cycle with done high, and the receiver must take it then. All work runs
// through one shared field unit, one command at a time. A point addition is
// 17 commands and a doubling 14 (three or four multiplications and one
// inversion). A scalar multiplication is up to SCALAR_BITS doublings plus
// one addition per set scalar bit; it stops early once the remaining scalar
// bits are zero or the doubled point is at infinity. The configuration port
// is 64 bits wide, register i at byte address 8*i.
module ecc_point_add_scalar_mul_gf3 import ecc3_pkg::*; #(
  parameter int MAX_DEGREE  = 31,
  parameter int SCALAR_BITS = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [4:0]             paddr,
  input  logic [63:0]            pwdata,
  output logic [63:0]            prdata,
  output logic                   pready,
  input  logic                   start,
  output logic                   busy,
  input  logic                   kind,
  input  logic [FIELD_W-1:0]     first_x,
  input  logic [FIELD_W-1:0]     first_y,
  input  logic                   first_inf,
  input  logic [FIELD_W-1:0]     second_x,
  input  logic [FIELD_W-1:0]     second_y,
  input  logic                   second_inf,
  input  logic [SCALAR_BITS-1:0] scalar,
  output logic                   done,
  output logic [FIELD_W-1:0]     result_x,
  output logic [FIELD_W-1:0]     result_y,
  output logic                   result_inf
);

  logic [DEG_W-1:0]   field_degree;
  logic [FIELD_W-1:0] modulus_low, coeff_a2, coeff_a4;
  logic               wr, capture;
  cmd_t               cmd;
  stat_t              stat;

  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite;
  assign capture = start && !busy;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      field_degree <= DEG_W'(3);
      modulus_low  <= FIELD_W'(5);
      coeff_a2     <= FIELD_W'(1);
      coeff_a4     <= FIELD_W'(1);
    end else if (wr) begin
      case (paddr[4:3])
        REG_DEGREE:  field_degree <= pwdata[DEG_W-1:0];
        REG_MODULUS: modulus_low  <= pwdata[FIELD_W-1:0];
        REG_A2:      coeff_a2     <= pwdata[FIELD_W-1:0];
        REG_A4:      coeff_a4     <= pwdata[FIELD_W-1:0];
        default:     field_degree <= field_degree;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (paddr[4:3])
      REG_DEGREE:  prdata = 64'(field_degree);
      REG_MODULUS: prdata = 64'(modulus_low);
      REG_A2:      prdata = 64'(coeff_a2);
      REG_A4:      prdata = 64'(coeff_a4);
      default:     prdata = '0;
    endcase
  end

  ecc3_ctrl #(.SCALAR_BITS(SCALAR_BITS)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .kind       (kind),
    .first_inf  (first_inf),
    .second_inf (second_inf),
    .scalar     (scalar),
    .stat       (stat),
    .cmd        (cmd),
    .busy       (busy),
    .done       (done),
    .result_inf (result_inf)
  );

  ecc3_dp #(.MAXD(MAX_DEGREE)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .capture      (capture),
    .first_x      (first_x),
    .first_y      (first_y),
    .second_x     (second_x),
    .second_y     (second_y),
    .field_degree (field_degree),
    .modulus_low  (modulus_low),
    .coeff_a2     (coeff_a2),
    .coeff_a4     (coeff_a4),
    .cmd          (cmd),
    .stat         (stat),
    .result_x     (result_x),
    .result_y     (result_y)
  );

endmodule

### dv/ecc_point_add_scalar_mul_gf3_tb.sv
// Testbench for the GF(3^m) affine point adder and scalar multiplier.
// It predicts each result with its own trit polynomial arithmetic and checks
// every word against it. Depends on ecc3_pkg and ecc_point_add_scalar_mul_gf3.
`timescale 1ns / 1ps

module ecc_point_add_scalar_mul_gf3_tb;
  import ecc3_pkg::*;

  localparam int MAXDEG = 31;
  localparam int SBITS = 64;
  localparam int TRITS = 64;
  localparam longint CYCLE_LIMIT = 20000000;

  typedef logic [2*TRITS-1:0] poly_t;

  typedef struct packed {
    poly_t x;
    poly_t y;
    logic inf;
  } point_t;

  typedef struct packed {
    logic kind;
    logic [FIELD_W-1:0] fx;
    logic [FIELD_W-1:0] fy;
    logic finf;
    logic [FIELD_W-1:0] sx;
    logic [FIELD_W-1:0] sy;
    logic sinf;
    logic [SBITS-1:0] k;
  } op_word_t;

  typedef struct packed {
    logic [FIELD_W-1:0] x;
    logic [FIELD_W-1:0] y;
    logic inf;
  } res_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic busy;
  logic kind = 1'b0;
  logic [FIELD_W-1:0] first_x = '0;
  logic [FIELD_W-1:0] first_y = '0;
  logic first_inf = 1'b0;
  logic [FIELD_W-1:0] second_x = '0;
  logic [FIELD_W-1:0] second_y = '0;
  logic second_inf = 1'b0;
  logic [SBITS-1:0] scalar = '0;
  logic done;
  logic [FIELD_W-1:0] result_x;
  logic [FIELD_W-1:0] result_y;
  logic result_inf;

  ecc_point_add_scalar_mul_gf3 #(.MAX_DEGREE(MAXDEG), .SCALAR_BITS(SBITS)) uut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy), .kind(kind), .first_x(first_x),
    .first_y(first_y), .first_inf(first_inf), .second_x(second_x),
    .second_y(second_y), .second_inf(second_inf), .scalar(scalar),
    .done(done), .result_x(result_x), .result_y(result_y),
    .result_inf(result_inf)
  );

  always #5 clk = ~clk;

  // register copies and derived field constants
  logic [4:0] cfg_degree = 5'd3;
  logic [61:0] cfg_modulus = 62'd5;
  logic [61:0] cfg_a2 = 62'd1;
  logic [61:0] cfg_a4 = 62'd1;
  int m_eff;
  poly_t modp, a2p, a4p;

  op_word_t pend_words[$];
  res_word_t exp_words[$];
  int idle_pct = 0;
  int n_issued = 0;
  int n_accepted = 0;
  int errors = 0;
  longint cycles = 0;

  function automatic int tg(poly_t p, int i);
    return int'(p[2*i +: 2]);
  endfunction

  function automatic int pdeg(poly_t p);
    for (int i = TRITS - 1; i >= 0; i--)
      if (p[2*i +: 2] != 2'd0) return i;
    return -1;
  endfunction

  function automatic poly_t reduce_p(poly_t p);
    int c, k;
    for (int i = TRITS - 1; i >= m_eff; i--) begin
      c = tg(p, i);
      if (c != 0) begin
        for (int j = 0; j <= m_eff; j++) begin
          k = i - m_eff + j;
          p[2*k +: 2] = 2'((tg(p, k) + 9 - c * tg(modp, j)) % 3);
        end
      end
    end
    return p;
  endfunction

  function automatic poly_t unpack_elem(logic [61:0] v);
    poly_t r;
    r = '0;
    for (int i = 0; i < 31; i++)
      r[2*i +: 2] = (v[2*i +: 2] == 2'd3) ? 2'd0 : v[2*i +: 2];
    return reduce_p(r);
  endfunction

  function automatic poly_t psub(poly_t a, poly_t b);
    poly_t r;
    for (int i = 0; i < TRITS; i++) r[2*i +: 2] = 2'((tg(a, i) + 3 - tg(b, i)) % 3);
    return r;
  endfunction

  function automatic poly_t pmul(poly_t a, poly_t b);
    poly_t r;
    r = '0;
    for (int i = 0; i < m_eff; i++)
      for (int j = 0; j < m_eff; j++)
        r[2*(i+j) +: 2] = 2'((tg(r, i + j) + tg(a, i) * tg(b, j)) % 3);
    return reduce_p(r);
  endfunction

  // extended Euclid; a non-invertible divisor yields zero
  function automatic poly_t pinv(poly_t a);
    poly_t r0, r1, s0, s1, t;
    int d0, d1, sh, c;
    r0 = modp; r1 = a; s0 = '0; s1 = '0; s1[1:0] = 2'd1;
    d1 = pdeg(r1);
    while (d1 >= 0) begin
      d0 = pdeg(r0);
      while (d0 >= d1) begin
        sh = d0 - d1;
        c = (tg(r0, d0) * tg(r1, d1)) % 3;
        for (int i = 0; i + sh < TRITS; i++) begin
          r0[2*(i+sh) +: 2] = 2'((tg(r0, i + sh) + 9 - c * tg(r1, i)) % 3);
          s0[2*(i+sh) +: 2] = 2'((tg(s0, i + sh) + 9 - c * tg(s1, i)) % 3);
        end
        d0 = pdeg(r0);
      end
      t = r0; r0 = r1; r1 = t;
      t = s0; s0 = s1; s1 = t;
      d1 = pdeg(r1);
    end
    t = '0;
    if (pdeg(r0) != 0) return t;
    for (int i = 0; i < TRITS; i++) t[2*i +: 2] = 2'((tg(s0, i) * tg(r0, 0)) % 3);
    return reduce_p(t);
  endfunction

  function automatic point_t pt_inf();
    point_t r;
    r = '0;
    r.inf = 1'b1;
    return r;
  endfunction

  function automatic point_t chord_finish(poly_t lam, poly_t x1, poly_t x2, poly_t y1);
    point_t r;
    r.x = psub(psub(psub(pmul(lam, lam), a2p), x1), x2);
    r.y = psub(pmul(psub(x1, r.x), lam), y1);
    r.inf = 1'b0;
    return r;
  endfunction

  function automatic point_t pt_double(point_t p);
    poly_t lam;
    if (p.inf || pdeg(p.y) < 0) return pt_inf();
    lam = pmul(psub(pmul(a2p, p.x), a4p), pinv(p.y));
    return chord_finish(lam, p.x, p.x, p.y);
  endfunction

  function automatic point_t pt_add(point_t a, point_t b);
    poly_t ny;
    if (a.inf && b.inf) return pt_inf();
    if (a.inf) return b;
    if (b.inf) return a;
    ny = psub('0, a.y);
    if (a.x == b.x && ny == b.y) return pt_inf();
    if (a.x == b.x && a.y == b.y) return pt_double(a);
    return chord_finish(pmul(psub(b.y, a.y), pinv(psub(b.x, a.x))), a.x, b.x, a.y);
  endfunction

  // expected result word for one accepted command
  function automatic res_word_t predict_point(op_word_t w);
    point_t p, q, r;
    res_word_t o;
    m_eff = (cfg_degree == 0) ? 1 : int'(cfg_degree);
    if (m_eff > MAXDEG) m_eff = MAXDEG;
    modp = '0;
    for (int i = 0; i < m_eff; i++)
      modp[2*i +: 2] = (cfg_modulus[2*i +: 2] == 2'd3) ? 2'd0 : cfg_modulus[2*i +: 2];
    modp[2*m_eff +: 2] = 2'd1;
    a2p = unpack_elem(cfg_a2);
    a4p = unpack_elem(cfg_a4);
    p.x = unpack_elem(w.fx); p.y = unpack_elem(w.fy); p.inf = w.finf;
    if (!w.kind) begin
      q.x = unpack_elem(w.sx); q.y = unpack_elem(w.sy); q.inf = w.sinf;
      r = pt_add(p, q);
    end else begin
      r = pt_inf();
      if (!p.inf) begin
        for (int i = 0; i < SBITS; i++) begin
          if (w.k[i]) r = pt_add(r, p);
          p = pt_double(p);
        end
      end
    end
    o = '0;
    if (!r.inf)
      for (int i = 0; i < m_eff; i++) begin
        o.x[2*i +: 2] = r.x[2*i +: 2];
        o.y[2*i +: 2] = r.y[2*i +: 2];
      end
    o.inf = r.inf;
    return o;
  endfunction

  // drive: hold a word until it is taken, then fetch the next or idle
  always @(negedge clk) begin
    op_word_t w;
    if (!rst && !(start && n_accepted != n_issued)) begin
      if (pend_words.size() > 0 && $urandom_range(99) >= idle_pct) begin
        w = pend_words.pop_front();
        kind <= w.kind; first_x <= w.fx; first_y <= w.fy; first_inf <= w.finf;
        second_x <= w.sx; second_y <= w.sy; second_inf <= w.sinf; scalar <= w.k;
        start <= 1'b1;
        n_issued = n_issued + 1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: predict on acceptance, check each result word
  always @(posedge clk) begin
    op_word_t w;
    res_word_t e;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
    if (!rst && start && !busy) begin
      w = '{kind, first_x, first_y, first_inf, second_x, second_y, second_inf, scalar};
      exp_words.push_back(predict_point(w));
      n_accepted = n_accepted + 1;
    end
    if (!rst && done) begin
      if (exp_words.size() == 0) begin
        $display("%0t: unexpected result word x=%h y=%h inf=%b",
                 $time, result_x, result_y, result_inf);
        errors = errors + 1;
      end else begin
        e = exp_words.pop_front();
        if (result_x !== e.x) begin
          $display("%0t: result_x expected %h actual %h", $time, e.x, result_x);
          errors = errors + 1;
        end
        if (result_y !== e.y) begin
          $display("%0t: result_y expected %h actual %h", $time, e.y, result_y);
          errors = errors + 1;
        end
        if (result_inf !== e.inf) begin
          $display("%0t: result_inf expected %b actual %b", $time, e.inf, result_inf);
          errors = errors + 1;
        end
      end
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [63:0] v);
    @(negedge clk);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = 5'(idx) << 3; pwdata = v;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    case (idx)
      REG_DEGREE:  cfg_degree = v[4:0];
      REG_MODULUS: cfg_modulus = v[61:0];
      REG_A2:      cfg_a2 = v[61:0];
      default:     cfg_a4 = v[61:0];
    endcase
  endtask

  task automatic set_field(logic [63:0] deg, logic [63:0] md, logic [63:0] a2,
                           logic [63:0] a4);
    reg_write(REG_DEGREE, deg);
    reg_write(REG_MODULUS, md);
    reg_write(REG_A2, a2);
    reg_write(REG_A4, a4);
  endtask

  // wait until every word has been taken and answered
  task automatic drain();
    while (pend_words.size() != 0 || start || exp_words.size() != 0 || busy)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  function automatic logic [61:0] rnd62();
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    return v[61:0];
  endfunction

  function automatic logic [61:0] rnd_elem(int m);
    logic [61:0] v;
    v = '0;
    for (int i = 0; i < m && i < 31; i++) v[2*i +: 2] = 2'($urandom_range(2));
    return v;
  endfunction

  function automatic logic [61:0] neg_elem(logic [61:0] v);
    for (int i = 0; i < 31; i++) v[2*i +: 2] = tneg(v[2*i +: 2]);
    return v;
  endfunction

  function automatic op_word_t mk_add(logic [61:0] fx, logic [61:0] fy, logic fi,
                                      logic [61:0] sx, logic [61:0] sy, logic si);
    op_word_t w;
    w = '{1'b0, fx, fy, fi, sx, sy, si, 64'(0)};
    return w;
  endfunction

  function automatic op_word_t mk_mul(logic [61:0] fx, logic [61:0] fy, logic fi,
                                      logic [63:0] k);
    op_word_t w;
    w = '{1'b1, fx, fy, fi, rnd62(), rnd62(), 1'($urandom_range(1)), k};
    return w;
  endfunction

  // random mix: mostly reduced points with related pairs, some raw noise
  task automatic queue_random(int n, int m, int big_pct);
    op_word_t w;
    logic [61:0] x, y;
    logic [63:0] k;
    int sel;
    for (int i = 0; i < n; i++) begin
      x = rnd_elem(m); y = rnd_elem(m);
      sel = $urandom_range(99);
      if ($urandom_range(99) < big_pct) k = {$urandom(), $urandom()};
      else k = 64'($urandom_range(255));
      if (sel < 15) w = mk_add(rnd62(), rnd62(), 1'($urandom_range(1)),
                               rnd62(), rnd62(), 1'($urandom_range(1)));
      else if (sel < 35) w = mk_add(x, y, 1'b0, rnd_elem(m), rnd_elem(m), 1'b0);
      else if (sel < 45) w = mk_add(x, y, 1'b0, x, y, 1'b0);
      else if (sel < 52) w = mk_add(x, y, 1'b0, x, neg_elem(y), 1'b0);
      else if (sel < 57) w = mk_add(x, y, $urandom_range(3) == 0, x, y, 1'b1);
      else if (sel < 65) w = mk_mul(rnd62(), rnd62(), $urandom_range(7) == 0, k);
      else w = mk_mul(x, y, 1'b0, k);
      pend_words.push_back(w);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed words under the reset curve, m = 3
    pend_words.push_back(mk_add('0, '0, 1'b0, '0, '0, 1'b0));
    pend_words.push_back(mk_add(62'h1, 62'h2, 1'b0, 62'h4, 62'h6, 1'b0));
    pend_words.push_back(mk_add(62'h5, 62'h9, 1'b0, 62'h5, neg_elem(62'h9), 1'b0));
    pend_words.push_back(mk_add(62'h6, 62'h1, 1'b0, 62'h6, 62'h1, 1'b0));
    pend_words.push_back(mk_add(62'h6, 62'h0, 1'b0, 62'h6, 62'h0, 1'b0));
    pend_words.push_back(mk_add(62'h1, 62'h1, 1'b1, 62'h2, 62'h5, 1'b0));
    pend_words.push_back(mk_add(62'h1, 62'h1, 1'b0, 62'h2, 62'h5, 1'b1));
    pend_words.push_back(mk_add(62'h1, 62'h1, 1'b1, 62'h2, 62'h5, 1'b1));
    pend_words.push_back(mk_add({62{1'b1}}, {62{1'b1}}, 1'b0, 62'h15, 62'h2a, 1'b0));
    pend_words.push_back(mk_add(62'h2aa, {31{2'b10}}, 1'b0, {31{2'b01}}, 62'h3f, 1'b0));
    pend_words.push_back(mk_add(62'h1, 62'h2, 1'b0, 62'h9, 62'h2, 1'b0));
    pend_words.push_back(mk_mul(62'h1, 62'h2, 1'b0, 64'd0));
    pend_words.push_back(mk_mul(62'h1, 62'h2, 1'b1, 64'd5));
    pend_words.push_back(mk_mul(62'h6, 62'h1, 1'b0, 64'd1));
    pend_words.push_back(mk_mul(62'h6, 62'h1, 1'b0, 64'd2));
    pend_words.push_back(mk_mul(62'h2, 62'h0, 1'b0, 64'd7));
    pend_words.push_back(mk_mul(62'h5, 62'h9, 1'b0, {64{1'b1}}));
    pend_words.push_back(mk_mul(62'h5, 62'h9, 1'b0, 64'h8000_0000_0000_0000));
    pend_words.push_back(mk_mul({62{1'b1}}, 62'h15, 1'b0, 64'd13));
    drain();

    // x^5 - x + 1, reduced coefficients, no idling
    set_field(64'd5, 64'd9, 64'(rnd_elem(5)), 64'(rnd_elem(5)));
    queue_random(20, 5, 5);
    drain();

    // random degree 7 modulus, sender mostly idle
    idle_pct = 78;
    set_field(64'd7, 64'(rnd62()), 64'(rnd62()), 64'(rnd62()));
    queue_random(20, 7, 5);
    drain();

    // largest degree, all-ones registers and upper bits set
    idle_pct = 14;
    set_field({64{1'b1}}, {64{1'b1}}, {64{1'b1}}, {64{1'b1}});
    queue_random(8, 31, 10);
    drain();

    // largest degree with a random modulus
    idle_pct = 0;
    set_field(64'd31, 64'(rnd62()), 64'(rnd62()), 64'(rnd62()));
    queue_random(6, 31, 0);
    drain();

    // degree zero used as one, then an even degree, minimal registers
    idle_pct = 78;
    set_field(64'd0, 64'd0, 64'd0, 64'd0);
    queue_random(8, 1, 5);
    drain();
    idle_pct = 14;
    set_field(64'd4, 64'(rnd62()), 64'(rnd62()), 64'(rnd62()));
    queue_random(15, 4, 5);
    drain();

    repeat (20) @(negedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/ecc3_pkg.sv
rtl/core/ecc3_inv.sv
rtl/core/ecc3_dp.sv
rtl/core/ecc3_ctrl.sv
rtl/core/ecc_point_add_scalar_mul_gf3.sv
dv/ecc_point_add_scalar_mul_gf3_tb.sv
